[sv/mpe_pkg.sv]
// mpe_pkg: shared types, constants and helpers for the MPE channel allocator.
// No dependencies; imported by every module of the block.
package mpe_pkg;

  localparam int SLOT_COUNT = 15;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CH_W       = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_BEND     = 4'hE;
  localparam logic [3:0] KIND_PRESSURE = 4'hD;
  localparam logic [3:0] KIND_CC       = 4'hB;

  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // index of the final control change of the zone setup burst
  localparam logic [2:0] CFG_LAST = 3'd5;

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_BEND     = 2'd2,
    ACT_PRESSURE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CFG
  } state_t;

  typedef struct packed {
    logic [6:0]  pressure;
    logic signed [13:0] bend;
    logic [6:0]  velocity;
    logic [6:0]  note;
    action_t     action;
  } item_t;

  typedef struct packed {
    logic       last;
    logic [1:0] msg_length;
    logic [6:0] data_two;
    logic [6:0] data_one;
    logic [7:0] status_byte;
  } msg_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       evt_exec;
    logic       cfg_emit;
    logic [2:0] cfg_idx;
    logic       cfg_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_note_on;
    logic free_found;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [6:0] d1;
    logic [6:0] d2;
  } cc_pair_t;

  // MPE zone setup: RPN 6 (zone size), then RPN null
  function automatic cc_pair_t cfg_msg(input logic [2:0] idx);
    cc_pair_t p;
    unique case (idx)
      3'd0:    p = '{d1: 7'd101, d2: 7'd0};
      3'd1:    p = '{d1: 7'd100, d2: 7'd6};
      3'd2:    p = '{d1: 7'd6,   d2: 7'(SLOT_COUNT)};
      3'd3:    p = '{d1: 7'd38,  d2: 7'd0};
      3'd4:    p = '{d1: 7'd101, d2: 7'd127};
      3'd5:    p = '{d1: 7'd100, d2: 7'd127};
      default: p = '{d1: 7'd0,   d2: 7'd0};
    endcase
    return p;
  endfunction

endpackage

[sv/mpe_channel_allocator.sv]
// mpe_channel_allocator: top level of the MPE member-channel allocator.
// Depends on mpe_pkg, mpe_ctrl and mpe_dp.
//
//  channel | dir | payload                                   | end marker
//  --------+-----+-------------------------------------------+-----------
//  in_*    | in  | note event word (action/note/vel/bend/pr) | none
//  out_*   | out | one MIDI message word                     | out_tlast
//
// An event is accepted in ST_IDLE, then slot lookup and update happen in ST_EVAL
// once the output register is free; lookup is a parallel compare over all slots.
// The first note on after reset first enters the setup burst (ST_CFG), which
// emits its six words, then the note on itself is evaluated again.
// A stalled output holds the block in its current step; no input is taken
// until the event's final word is in the output register.
// rst_n (synchronous, low) frees every slot and re-arms the setup burst.
module mpe_channel_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] action, [8:2] note, [15:9] velocity, [29:16] bend, [36:30] pressure
  input  logic [mpe_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] status_byte, [14:8] data_one, [21:15] data_two, [23:22] msg_length
  output logic [mpe_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import mpe_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  item_t in_item;
  msg_t  out_msg;

  assign in_item = item_t'(in_tdata[$bits(item_t)-1:0]);

  mpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_msg   (out_msg)
  );

  assign out_tdata = {out_msg.msg_length, out_msg.data_two, out_msg.data_one,
                      out_msg.status_byte};
  assign out_tlast = out_msg.last;

endmodule

[sv/mpe_ctrl.sv]
// mpe_ctrl: sequencing FSM for the allocator (accept, setup burst, event).
// Depends on mpe_pkg.
module mpe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mpe_pkg::sts_t sts,
  output mpe_pkg::cmd_t cmd
);
  import mpe_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       configured_r, configured_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      configured_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      configured_r <= configured_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    configured_nxt = configured_r;
    in_tready      = 1'b0;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.out_free) begin
          if (sts.is_note_on && !configured_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_CFG;
          end else begin
            cmd.evt_exec = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_CFG: begin
        if (sts.out_free) begin
          cmd.cfg_emit = 1'b1;
          cmd.cfg_idx  = cnt_r;
          // burst carries the last flag when the note on finds no slot
          cmd.cfg_last = (cnt_r == CFG_LAST) && !sts.free_found;
          if (cnt_r == CFG_LAST) begin
            configured_nxt = 1'b1;
            state_nxt      = ST_EVAL;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_cfg_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CFG |-> !configured_r)
    else $error("setup burst running after zone configured");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CFG |-> cnt_r <= CFG_LAST)
    else $error("setup counter out of range");

  a_cfg_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cfg_emit && cmd.cfg_idx == CFG_LAST |=> configured_r && state_r == ST_EVAL)
    else $error("zone not marked configured after burst");

endmodule

[sv/mpe_dp.sv]
// mpe_dp: item register, slot table with parallel note compare, message build
// and output word register. Depends on mpe_pkg; driven by mpe_ctrl.
module mpe_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  mpe_pkg::item_t in_item,
  input  mpe_pkg::cmd_t  cmd,
  output mpe_pkg::sts_t  sts,
  output logic           out_valid,
  input  logic           out_ready,
  output mpe_pkg::msg_t  out_msg
);
  import mpe_pkg::*;

  item_t                 item_r;
  logic [SLOT_COUNT-1:0] slot_active_r, slot_active_nxt;
  logic [6:0]            slot_note_r [SLOT_COUNT];
  logic                  out_valid_r, out_valid_nxt;
  msg_t                  out_msg_r, out_msg_nxt;

  logic             free_found, hit;
  logic [IDX_W-1:0] free_idx, hit_idx, ch_idx;
  logic [CH_W-1:0]  ch;
  logic             note_wr;
  logic [13:0]      bend_off;
  cc_pair_t         cc;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  // lowest free slot and lowest active slot holding the note
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit        = 1'b0;
    hit_idx    = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (slot_active_r[i] && slot_note_r[i] == item_r.note) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign ch_idx   = (item_r.action == ACT_NOTE_ON) ? free_idx : hit_idx;
  assign ch       = CH_W'(ch_idx) + CH_W'(1);
  assign bend_off = {~item_r.bend[13], item_r.bend[12:0]};
  assign cc       = cfg_msg(cmd.cfg_idx);

  assign sts.is_note_on = (item_r.action == ACT_NOTE_ON);
  assign sts.free_found = free_found;
  assign sts.out_free   = out_free;

  always_comb begin
    slot_active_nxt = slot_active_r;
    note_wr         = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_msg_nxt     = out_msg_r;
    if (cmd.cfg_emit) begin
      out_valid_nxt = 1'b1;
      out_msg_nxt   = '{last: cmd.cfg_last, msg_length: LEN_THREE, data_two: cc.d2,
                        data_one: cc.d1, status_byte: {KIND_CC, 4'h0}};
    end else if (cmd.evt_exec) begin
      unique case (item_r.action)
        ACT_NOTE_ON: begin
          if (free_found) begin
            slot_active_nxt[free_idx] = 1'b1;
            note_wr       = 1'b1;
            out_valid_nxt = 1'b1;
            out_msg_nxt   = '{last: 1'b1, msg_length: LEN_THREE,
                              data_two: item_r.velocity, data_one: item_r.note,
                              status_byte: {KIND_NOTE_ON, ch}};
          end
        end
        ACT_NOTE_OFF: begin
          if (hit) begin
            slot_active_nxt[hit_idx] = 1'b0;
            out_valid_nxt = 1'b1;
            out_msg_nxt   = '{last: 1'b1, msg_length: LEN_THREE, data_two: 7'd0,
                              data_one: item_r.note, status_byte: {KIND_NOTE_OFF, ch}};
          end
        end
        ACT_BEND: begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_msg_nxt   = '{last: 1'b1, msg_length: LEN_THREE,
                              data_two: bend_off[13:7], data_one: bend_off[6:0],
                              status_byte: {KIND_BEND, ch}};
          end
        end
        ACT_PRESSURE: begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_msg_nxt   = '{last: 1'b1, msg_length: LEN_TWO, data_two: 7'd0,
                              data_one: item_r.pressure,
                              status_byte: {KIND_PRESSURE, ch}};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_active_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      slot_active_r <= slot_active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (note_wr) slot_note_r[free_idx] <= item_r.note;
    out_msg_r <= out_msg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_msg   = out_msg_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cfg_emit || cmd.evt_exec) |-> out_free)
    else $error("output word overwritten while stalled");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.cfg_emit && cmd.evt_exec) && !(cmd.load && (cmd.cfg_emit || cmd.evt_exec)))
    else $error("conflicting datapath commands");

  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evt_exec && item_r.action == ACT_NOTE_ON && free_found
    |=> slot_active_r[$past(free_idx)] && out_valid_r && out_msg_r.last)
    else $error("note on did not claim its slot");

endmodule
